FILE: rtl/core/lsa_pkg.sv
// Shared types, constants and helpers for the latency statistics accumulator.
// Used by every module under rtl/core; depends on nothing.
package lsa_pkg;

  localparam int unsigned STAT_W      = 32;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned FIFO_DEPTH  = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 232;
  // radix-4 divider: two quotient bits per cycle
  localparam int unsigned DIV_CYCLES  = SUM_W / 2;

  localparam logic [STAT_W-1:0] SLOW_RESET = 32'd100000;
  localparam logic [STAT_W-1:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam logic [SUM_W-1:0]  ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic ACTION_RECORD = 1'b0;
  localparam logic ACTION_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_FAIL,
    KIND_GOOD
  } lsa_kind_e;

  typedef struct packed {
    lsa_kind_e          kind;
    logic               slow;
    logic [STAT_W-1:0]  latency;
  } lsa_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] tested;
    logic [STAT_W-1:0] passed;
    logic [STAT_W-1:0] errors;
    logic [STAT_W-1:0] slow;
    logic [SUM_W-1:0]  sum;
    logic [STAT_W-1:0] lat_min;
    logic [STAT_W-1:0] lat_max;
  } lsa_stats_t;

  // cleared statistics: minimum all ones, everything else zero
  localparam lsa_stats_t STATS_CLEAR = '{
    tested:  '0,
    passed:  '0,
    errors:  '0,
    slow:    '0,
    sum:     '0,
    lat_min: ALL_ONES32,
    lat_max: '0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } lsa_state_e;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    sat_inc = (v == ALL_ONES32) ? v : v + 32'd1;
  endfunction

endpackage

FILE: rtl/core/lsa_front.sv
// Front end: input stream acceptance, threshold register, item classification.
// Depends on lsa_pkg.
module lsa_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsa_pkg::STAT_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [lsa_pkg::STAT_W-1:0]          latency_i,
  input  logic                                read_ok_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output lsa_pkg::lsa_item_t                  q_item_o
);

  logic [lsa_pkg::STAT_W-1:0] thr_q, thr_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thr_d = thr_q;
    if (cfg_valid_i) begin
      thr_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= lsa_pkg::SLOW_RESET;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.latency = latency_i;
    q_item_o.slow    = latency_i > thr_q;
    if (action_i == lsa_pkg::ACTION_CLEAR) begin
      q_item_o.kind = lsa_pkg::KIND_CLEAR;
    end else if (read_ok_i) begin
      q_item_o.kind = lsa_pkg::KIND_GOOD;
    end else begin
      q_item_o.kind = lsa_pkg::KIND_FAIL;
    end
  end

endmodule

FILE: rtl/core/lsa_fifo.sv
// Short item queue between front and back end.
// Depends on lsa_pkg.
module lsa_fifo #(
  parameter int unsigned Depth = lsa_pkg::FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lsa_pkg::lsa_item_t wr_item_i,
  input  logic               pop_i,
  output lsa_pkg::lsa_item_t rd_item_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lsa_pkg::lsa_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  assign full_o    = cnt_q == CntW'(Depth);
  assign empty_o   = cnt_q == '0;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

FILE: rtl/core/lsa_div.sv
// Radix-4 restoring divider, 64-bit dividend by 32-bit divisor.
// Depends on lsa_pkg.
module lsa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lsa_pkg::SUM_W-1:0]  dividend_i,
  input  logic [lsa_pkg::STAT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [lsa_pkg::SUM_W-1:0]  quotient_o
);

  localparam int unsigned CntW = $clog2(lsa_pkg::DIV_CYCLES);

  logic [lsa_pkg::SUM_W-1:0]  dq_q, dq_d;
  logic [lsa_pkg::STAT_W-1:0] rem_q, rem_d, dvs_q;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;

  logic [lsa_pkg::STAT_W:0]   r1, r2, dvs_x;
  logic [lsa_pkg::STAT_W-1:0] rem1;
  logic                       ge1, ge2;

  // two dependent shift-subtract steps per cycle
  always_comb begin
    dvs_x = {1'b0, dvs_q};
    r1    = {rem_q, dq_q[lsa_pkg::SUM_W-1]};
    ge1   = r1 >= dvs_x;
    rem1  = ge1 ? lsa_pkg::STAT_W'(r1 - dvs_x) : r1[lsa_pkg::STAT_W-1:0];
    r2    = {rem1, dq_q[lsa_pkg::SUM_W-2]};
    ge2   = r2 >= dvs_x;
  end

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(lsa_pkg::DIV_CYCLES - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dq_d  = {dq_q[lsa_pkg::SUM_W-3:0], ge1, ge2};
      rem_d = ge2 ? lsa_pkg::STAT_W'(r2 - dvs_x) : r2[lsa_pkg::STAT_W-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: rtl/core/lsa_back.sv
// Back end: statistics registers, update sequencer, average divider, result hold.
// Depends on lsa_pkg and lsa_div.
module lsa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lsa_pkg::lsa_item_t         item_i,
  input  logic                       item_avail_i,
  output logic                       pop_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output lsa_pkg::lsa_stats_t        stats_o,
  output logic [lsa_pkg::STAT_W-1:0] avg_o
);

  lsa_pkg::lsa_state_e        state_q, state_d;
  lsa_pkg::lsa_stats_t        stats_q, stats_d;
  logic [lsa_pkg::STAT_W-1:0] avg_q, avg_d;
  logic [lsa_pkg::SUM_W:0]    sum_x;
  logic                       div_start, div_done;
  logic [lsa_pkg::SUM_W-1:0]  quot;

  lsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (stats_q.sum),
    .divisor_i  (stats_q.tested),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsa_pkg::ST_IDLE: begin
        if (item_avail_i) begin
          state_d = lsa_pkg::ST_LOAD;
        end
      end
      lsa_pkg::ST_LOAD: state_d = lsa_pkg::ST_DIV;
      lsa_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lsa_pkg::ST_OUT;
        end
      end
      lsa_pkg::ST_OUT: begin
        if (res_ready_i) begin
          state_d = lsa_pkg::ST_IDLE;
        end
      end
      default: state_d = lsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    div_start   = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      lsa_pkg::ST_IDLE: pop_o       = item_avail_i;
      lsa_pkg::ST_LOAD: div_start   = 1'b1;
      lsa_pkg::ST_OUT:  res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    sum_x   = {1'b0, stats_q.sum} + {{(lsa_pkg::SUM_W-lsa_pkg::STAT_W+1){1'b0}}, item_i.latency};
    stats_d = stats_q;
    if (pop_o) begin
      unique case (item_i.kind)
        lsa_pkg::KIND_CLEAR: stats_d = lsa_pkg::STATS_CLEAR;
        lsa_pkg::KIND_FAIL: begin
          stats_d.tested = lsa_pkg::sat_inc(stats_q.tested);
          stats_d.errors = lsa_pkg::sat_inc(stats_q.errors);
        end
        lsa_pkg::KIND_GOOD: begin
          stats_d.tested = lsa_pkg::sat_inc(stats_q.tested);
          stats_d.passed = lsa_pkg::sat_inc(stats_q.passed);
          stats_d.sum    = sum_x[lsa_pkg::SUM_W] ? lsa_pkg::ALL_ONES64
                                                 : sum_x[lsa_pkg::SUM_W-1:0];
          if (item_i.latency < stats_q.lat_min) begin
            stats_d.lat_min = item_i.latency;
          end
          if (item_i.latency > stats_q.lat_max) begin
            stats_d.lat_max = item_i.latency;
          end
          if (item_i.slow) begin
            stats_d.slow = lsa_pkg::sat_inc(stats_q.slow);
          end
        end
        default: ;
      endcase
    end
  end

  // quotient above 32 bits only once counts have saturated: clip it
  always_comb begin
    avg_d = avg_q;
    if (state_q == lsa_pkg::ST_DIV && div_done) begin
      if (stats_q.tested == '0) begin
        avg_d = '0;
      end else if (quot[lsa_pkg::SUM_W-1:lsa_pkg::STAT_W] != '0) begin
        avg_d = lsa_pkg::ALL_ONES32;
      end else begin
        avg_d = quot[lsa_pkg::STAT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsa_pkg::ST_IDLE;
      stats_q <= lsa_pkg::STATS_CLEAR;
    end else begin
      state_q <= state_d;
      stats_q <= stats_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
  end

  assign stats_o = stats_q;
  assign avg_o   = avg_q;

endmodule

FILE: rtl/core/latency_statistics_accumulator_top.sv
// A result follows its item through the queue, the statistics update and then the
// radix-4 divider that forms the average; the back end takes no new item from the
// queue until that result is accepted; the input queue keeps taking items while a
// result waits, until it is full.
// Reset (rst_ni low, asynchronous): statistics cleared, minimum all ones,
// slow threshold 100000, queue empty.
module latency_statistics_accumulator_top #(
  parameter int unsigned FifoDepth = lsa_pkg::FIFO_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsa_pkg::STAT_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] latency, [32] read_ok, [39:33] zero
  input  logic [lsa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] action
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] count_tested, [63:32] count_passed, [95:64] count_errors,
  // [127:96] count_slow, [159:128] latency_min, [191:160] latency_max,
  // [223:192] latency_avg, [224] all_passed, [231:225] zero
  output logic [lsa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  lsa_pkg::lsa_item_t         push_item, pop_item;
  lsa_pkg::lsa_stats_t        stats;
  logic                       push, pop, q_full, q_empty;
  logic [lsa_pkg::STAT_W-1:0] avg;

  lsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser[0]),
    .latency_i   (s_axis_tdata[lsa_pkg::STAT_W-1:0]),
    .read_ok_i   (s_axis_tdata[lsa_pkg::STAT_W]),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_item_o    (push_item)
  );

  lsa_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_item_i (push_item),
    .pop_i     (pop),
    .rd_item_o (pop_item),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  lsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (pop_item),
    .item_avail_i (!q_empty),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .stats_o      (stats),
    .avg_o        (avg)
  );

  assign m_axis_tdata = {7'd0, (stats.errors == '0), avg, stats.lat_max, stats.lat_min,
                         stats.slow, stats.errors, stats.passed, stats.tested};

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for latency_statistics_accumulator_top.
// Drives measurement and clear items over the slave stream and threshold writes,
// checks every result against an in-bench statistics predictor; needs lsa_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic                       action;
    logic [lsa_pkg::STAT_W-1:0] latency;
    logic                       ok;
  } read_item_t;

  // [0] tested [1] passed [2] errors [3] slow [4] min [5] max [6] avg [7] all_passed
  typedef logic [7:0][lsa_pkg::STAT_W-1:0] report_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [lsa_pkg::STAT_W-1:0]      cfg_data_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  latency_statistics_accumulator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  string field_names [8] = '{"count_tested", "count_passed", "count_errors", "count_slow",
                             "latency_min", "latency_max", "latency_avg", "all_passed"};

  read_item_t pending_items [$];
  report_t    expected_reports [$];
  read_item_t in_flight;
  int         idle_pct = 36;
  int         mismatches = 0;
  int         results_seen = 0;
  int         n_clears = 0;
  int         n_good = 0;
  int         n_failed = 0;
  int         n_thresholds = 0;

  // predicted statistics
  logic [lsa_pkg::STAT_W-1:0] slow_thr = lsa_pkg::SLOW_RESET;
  logic [lsa_pkg::STAT_W-1:0] tested_cnt = '0;
  logic [lsa_pkg::STAT_W-1:0] passed_cnt = '0;
  logic [lsa_pkg::STAT_W-1:0] error_cnt = '0;
  logic [lsa_pkg::STAT_W-1:0] slow_cnt = '0;
  logic [lsa_pkg::SUM_W-1:0]  lat_sum = '0;
  logic [lsa_pkg::STAT_W-1:0] lat_min = lsa_pkg::ALL_ONES32;
  logic [lsa_pkg::STAT_W-1:0] lat_max = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic report_t record_item(input read_item_t it);
    report_t                   r;
    logic [lsa_pkg::SUM_W:0]   wide_sum;
    logic [lsa_pkg::SUM_W-1:0] quot;
    if (it.action == lsa_pkg::ACTION_CLEAR) begin
      tested_cnt = '0;
      passed_cnt = '0;
      error_cnt  = '0;
      slow_cnt   = '0;
      lat_sum    = '0;
      lat_min    = lsa_pkg::ALL_ONES32;
      lat_max    = '0;
    end else begin
      if (tested_cnt != lsa_pkg::ALL_ONES32) tested_cnt = tested_cnt + 32'd1;
      if (!it.ok) begin
        if (error_cnt != lsa_pkg::ALL_ONES32) error_cnt = error_cnt + 32'd1;
      end else begin
        if (passed_cnt != lsa_pkg::ALL_ONES32) passed_cnt = passed_cnt + 32'd1;
        wide_sum = {1'b0, lat_sum}
                   + {{(lsa_pkg::SUM_W-lsa_pkg::STAT_W+1){1'b0}}, it.latency};
        lat_sum  = wide_sum[lsa_pkg::SUM_W] ? lsa_pkg::ALL_ONES64
                                            : wide_sum[lsa_pkg::SUM_W-1:0];
        if (it.latency < lat_min) lat_min = it.latency;
        if (it.latency > lat_max) lat_max = it.latency;
        if (it.latency > slow_thr && slow_cnt != lsa_pkg::ALL_ONES32) begin
          slow_cnt = slow_cnt + 32'd1;
        end
      end
    end
    r[0] = tested_cnt;
    r[1] = passed_cnt;
    r[2] = error_cnt;
    r[3] = slow_cnt;
    r[4] = lat_min;
    r[5] = lat_max;
    if (tested_cnt == '0) begin
      r[6] = '0;
    end else begin
      quot = lat_sum / {{(lsa_pkg::SUM_W-lsa_pkg::STAT_W){1'b0}}, tested_cnt};
      r[6] = (quot > {{(lsa_pkg::SUM_W-lsa_pkg::STAT_W){1'b0}}, lsa_pkg::ALL_ONES32})
             ? lsa_pkg::ALL_ONES32 : quot[lsa_pkg::STAT_W-1:0];
    end
    r[7] = {31'b0, (error_cnt == '0)};
    return r;
  endfunction

  // slave-side driver: holds an item until accepted, then maybe idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reports.push_back(record_item(in_flight));
        if (in_flight.action == lsa_pkg::ACTION_CLEAR) n_clears++;
        else if (in_flight.ok) n_good++;
        else n_failed++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_flight = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, in_flight.ok, in_flight.latency};
          s_axis_tuser  <= in_flight.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // master-side monitor
  always @(posedge clk_i) begin
    report_t want;
    report_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      for (int i = 0; i < 7; i++) got[i] = m_axis_tdata[32*i +: 32];
      got[7] = {31'b0, m_axis_tdata[224]};
      if (expected_reports.size() == 0) begin
        $display("%0t: result with nothing expected, tested=%0d", $time, got[0]);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: %s expected %h actual %h", $time, field_names[i], want[i], got[i]);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic add_item(input logic action, input logic [lsa_pkg::STAT_W-1:0] lat,
                          input logic ok);
    read_item_t it;
    it.action  = action;
    it.latency = lat;
    it.ok      = ok;
    pending_items.push_back(it);
  endtask

  // checked between edges so the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
  endtask

  task automatic write_threshold(input logic [lsa_pkg::STAT_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    slow_thr = value;
    n_thresholds++;
  endtask

  function automatic logic [lsa_pkg::STAT_W-1:0] pick_latency();
    logic [lsa_pkg::STAT_W-1:0] delta;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1000);
      1: begin
        // straddle the threshold, wrapping at the ends
        delta = $urandom_range(0, 4);
        return slow_thr + delta - 32'd2;
      end
      2: return $urandom_range(0, 1) ? lsa_pkg::ALL_ONES32 : '0;
      3: return $urandom_range(50000, 200000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_run(input int n);
    int fail_pct;
    fail_pct = 12;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 49) == 0) begin
        add_item(lsa_pkg::ACTION_CLEAR, $urandom, 1'($urandom_range(0, 1)));
        // some runs after a clear stay clean, some get error bursts
        fail_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40);
      end else begin
        add_item(lsa_pkg::ACTION_RECORD, pick_latency(), $urandom_range(0, 99) >= fail_pct);
      end
    end
  endtask

  initial begin
    logic [lsa_pkg::STAT_W-1:0] settings [6];
    settings = '{32'd0, lsa_pkg::ALL_ONES32, $urandom, 32'd1, lsa_pkg::SLOW_RESET,
                 $urandom_range(1000, 300000)};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, under the reset threshold
    add_item(lsa_pkg::ACTION_RECORD, 32'd5000, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, '0, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, lsa_pkg::ALL_ONES32, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, lsa_pkg::SLOW_RESET, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, lsa_pkg::SLOW_RESET + 32'd1, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, 32'hAAAA_AAAA, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, 32'h5555_5555, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, lsa_pkg::ALL_ONES32, 1'b0);
    add_item(lsa_pkg::ACTION_RECORD, 32'd7, 1'b1);
    add_item(lsa_pkg::ACTION_CLEAR, lsa_pkg::ALL_ONES32, 1'b1);
    add_item(lsa_pkg::ACTION_CLEAR, '0, 1'b0);
    // failed read first: no sum, average still zero
    add_item(lsa_pkg::ACTION_RECORD, 32'h1234_5678, 1'b0);
    add_item(lsa_pkg::ACTION_RECORD, 32'd300, 1'b1);
    add_item(lsa_pkg::ACTION_CLEAR, 32'h5555_5555, 1'b0);
    add_item(lsa_pkg::ACTION_RECORD, lsa_pkg::ALL_ONES32, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, lsa_pkg::ALL_ONES32, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, lsa_pkg::ALL_ONES32, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, lsa_pkg::SLOW_RESET - 32'd1, 1'b1);
    add_item(lsa_pkg::ACTION_RECORD, 32'hAAAA_AAAA, 1'b0);
    add_item(lsa_pkg::ACTION_CLEAR, 32'hAAAA_AAAA, 1'b1);
    wait_drained();

    foreach (settings[p]) begin
      repeat (40) @(posedge clk_i);
      write_threshold(settings[p]);
      idle_pct = (p == 2) ? 0 : 36;
      if (p == 0 || p == 3) begin
        // straddle the new threshold right away
        add_item(lsa_pkg::ACTION_RECORD, settings[p], 1'b1);
        add_item(lsa_pkg::ACTION_RECORD, settings[p] + 32'd1, 1'b1);
      end
      add_random_run(250);
      wait_drained();
    end

    idle_pct = 36;
    repeat (40) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_reports.size());
      mismatches++;
    end
    $display("Covered %0d good reads, %0d failed reads, %0d clears under %0d thresholds;",
             n_good, n_failed, n_clears, n_thresholds + 1);
    $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
